/* design/wma_pkg.sv */
// shared constants and types of the windowed moving average unit
package wma_pkg;

   localparam int DATA_W         = 32;
   localparam int FILLED_W       = 5;
   localparam int DEFAULT_WINDOW = 16;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

/* design/windowed_moving_average_unit.sv */
// top level of the windowed moving average unit
//
//  channel   direction  handshake           payload
//  req_      in         req_valid/req_stall  req_sample
//  rsp_      out        rsp_valid/rsp_stall  rsp_mean, rsp_latest, rsp_filled
//
// one item at a time; the serial divider yields one quotient bit per cycle
// the ring read is registered; sum update and ring write follow in UPDATE
// reset clears fill count, write slot, running sum and all handshake state;
// the ring itself needs no clearing, entries are only used once written
// a stalled result sits in the output register; the next request is taken
// meanwhile and its result waits in the divider until the register frees
module windowed_moving_average_unit #(
   parameter int WINDOW = wma_pkg::DEFAULT_WINDOW
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [wma_pkg::DATA_W-1:0]    req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [wma_pkg::DATA_W-1:0]    rsp_mean,
   output logic [wma_pkg::DATA_W-1:0]    rsp_latest,
   output logic [wma_pkg::FILLED_W-1:0]  rsp_filled
);
   import wma_pkg::*;

   localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int FILL_W = $clog2(WINDOW + 1);
   localparam int SUM_W  = DATA_W + $clog2(WINDOW);

   typedef enum logic [1:0] {
      IDLE,
      UPDATE,
      DIVIDE
   } state_type;

   state_type              state_ff, state_in;
   logic [SLOT_W-1:0]      slot_ff, slot_in;
   logic [FILL_W-1:0]      fill_ff, fill_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [DATA_W-1:0]      sample_ff, sample_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]      rsp_mean_ff, rsp_mean_in;
   logic [DATA_W-1:0]      rsp_latest_ff, rsp_latest_in;
   logic [FILLED_W-1:0]    rsp_filled_ff, rsp_filled_in;

   logic                   req_take;
   logic                   out_free;
   logic                   window_full;
   logic                   ring_wr;
   logic [DATA_W-1:0]      oldest;
   logic                   div_start;
   logic [SUM_W-1:0]       quotient;
   div_status_type         div_status;

   assign req_take    = req_valid && (state_ff == IDLE);
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign window_full = fill_ff == FILL_W'(WINDOW);
   assign ring_wr     = state_ff == UPDATE;
   assign div_start   = state_ff == UPDATE;

   // ring of samples, read at the write slot so the oldest entry is at hand
   wma_ram #(
      .WIDTH (DATA_W),
      .DEPTH (WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_wr),
      .wr_addr (slot_ff),
      .wr_data (sample_ff),
      .rd_en   (req_take),
      .rd_addr (slot_ff),
      .rd_data (oldest)
   );

   // mean = running sum / fill count
   wma_div #(
      .DIVIDEND_W (SUM_W),
      .DIVISOR_W  (FILL_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_in),
      .divisor  (fill_in),
      .quotient (quotient),
      .status   (div_status)
   );

   always_comb begin
      state_in      = state_ff;
      slot_in       = slot_ff;
      fill_in       = fill_ff;
      sum_in        = sum_ff;
      sample_in     = sample_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_mean_in   = rsp_mean_ff;
      rsp_latest_in = rsp_latest_ff;
      rsp_filled_in = rsp_filled_ff;

      // the consumer takes the waiting result
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               sample_in = req_sample;
               state_in  = UPDATE;
            end
         end
         UPDATE: begin
            // full window: oldest sample leaves the sum, else the window grows
            if (window_full) begin
               sum_in = sum_ff - SUM_W'(oldest) + SUM_W'(sample_ff);
            end else begin
               sum_in  = sum_ff + SUM_W'(sample_ff);
               fill_in = fill_ff + FILL_W'(1);
            end
            slot_in  = (slot_ff == SLOT_W'(WINDOW - 1)) ? '0 : slot_ff + SLOT_W'(1);
            state_in = DIVIDE;
         end
         DIVIDE: begin
            if (div_status.done && out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_mean_in   = quotient[DATA_W-1:0];
               rsp_latest_in = sample_ff;
               rsp_filled_in = FILLED_W'(fill_ff);
               state_in      = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         slot_ff      <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff     <= sample_in;
      rsp_mean_ff   <= rsp_mean_in;
      rsp_latest_ff <= rsp_latest_in;
      rsp_filled_ff <= rsp_filled_in;
   end

   assign req_stall  = state_ff != IDLE;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_mean   = rsp_mean_ff;
   assign rsp_latest = rsp_latest_ff;
   assign rsp_filled = rsp_filled_ff;

   // fill count never passes the window size
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(WINDOW))
      else $error("fill count beyond window");

   // divider is quiet whenever a new request may be taken
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == IDLE |-> !div_status.busy)
      else $error("divider busy while idle");

   // a fresh result only comes out of the divide state with a finished quotient
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == DIVIDE && div_status.done))
      else $error("result loaded without finished divide");

   // a result always reports at least one stored sample
   a_rsp_filled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (fill_ff != '0))
      else $error("result with empty window");

endmodule

/* design/wma_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
module wma_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/wma_div.sv */
// restoring serial divider, one quotient bit per cycle
module wma_div #(
   parameter int DIVIDEND_W = 36,
   parameter int DIVISOR_W  = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic [DIVIDEND_W-1:0] quotient,
   output wma_pkg::div_status_type status
);
   import wma_pkg::*;

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dsr_ff, dsr_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIVISOR_W:0]    trial;
   logic                  fits;

   // partial remainder with the next dividend bit shifted in
   assign trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = CNT_W'(DIVIDEND_W);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         rem_in = fits ? DIVISOR_W'(trial - {1'b0, dsr_ff}) : DIVISOR_W'(trial);
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule
